@@ rtl/box_blur_3x3_macros.svh @@
// Assertion macros used by the box blur top level.
`ifndef BOX_BLUR_3X3_MACROS_SVH
`define BOX_BLUR_3X3_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BB3_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BB3_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bb3_pkg.sv @@
// Types, constants and helpers for the 3x3 box blur.
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 12;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam int WIN_SIDE      = 3;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    // floor(s / 9) == (s * 7282) >> 16 for every s below 2296.
    localparam int RECIP_W       = 13;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
    localparam int RECIP_SHIFT   = 16;
    localparam int PROD_W        = SUM_W + RECIP_W;

    // One column of the window, top to bottom.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    // One line store word: pixel two rows up and pixel one row up.
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } row_pair_t;

    function automatic logic [SUM_W-1:0] column_sum(input column_t c);
        column_sum = SUM_W'(c.top) + SUM_W'(c.mid) + SUM_W'(c.bot);
    endfunction

endpackage

@@ rtl/bb3_line_store.sv @@
// Two line stores packed into one simple dual-port memory with registered read.
module bb3_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output bb3_pkg::row_pair_t  rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  bb3_pkg::row_pair_t  wr_data
);
    import bb3_pkg::*;

    row_pair_t mem [DEPTH];
    row_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bb3_window.sv @@
// Window of the two previous strip columns plus the mean of the full 3x3 window.
module bb3_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  bb3_pkg::column_t           column,
    output logic [bb3_pkg::PIX_W-1:0]  mean
);
    import bb3_pkg::*;

    column_t                win_reg [2];
    logic [SUM_W-1:0]       sum;
    logic [PROD_W-1:0]      prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
        end
        else if (shift)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= column;
        end
    end

    // Nine-pixel sum, then divide by nine through the reciprocal.
    assign sum  = column_sum(win_reg[0]) + column_sum(win_reg[1]) + column_sum(column);
    assign prod = PROD_W'(sum) * PROD_W'(RECIP_NINE);
    assign mean = prod[RECIP_SHIFT +: PIX_W];

endmodule

@@ rtl/box_blur_3x3.sv @@
// Top level of the streaming 3x3 box blur.
//
// Takes an 8-bit grayscale frame in raster order, one pixel per clock, and
// returns floor(sum/9) of every complete 3x3 window, tagged with the window's
// top-left row and column; windows never wrap across a row end. Throughput is
// one pixel per clock unless the result channel stalls; a result passes through
// stage 1 and then the output register. The rate is set by the line store:
// one read (at accept) and one write (as the pixel leaves stage 1) per pixel
// on a simple dual-port memory of MAX_WIDTH words holding both previous rows.
// Writing image_width or image_height restarts the frame at row 0, column 0;
// the user must make writes only while the block is idle; the block does
// not enforce this. Widths are saturated to 3..MAX_WIDTH and heights to
// 3..4096. frame_done marks the result of the last pixel of each frame. Line
// store contents are undefined after reset and need no clearing pass: no
// result reads an entry not written in the current frame.
`include "box_blur_3x3_macros.svh"

module box_blur_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel channel
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [bb3_pkg::PIX_W-1:0]       gray_pixel,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [bb3_pkg::PIX_W-1:0]       blurred_value,
    output logic [bb3_pkg::ROW_W-1:0]       window_row,
    output logic [bb3_pkg::OUT_COL_W-1:0]   window_col,
    output logic                            frame_done,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bb3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [CFG_W_W-1:0] image_width_reg;
    logic [CFG_H_W-1:0] image_height_reg;
    logic               cfg_write;
    logic               cfg_restart;

    // Saturated last column / last row of the frame
    logic [COL_W-1:0]   last_col;
    logic [ROW_W-1:0]   last_row;

    // Frame position of the next pixel
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    // Stage 1: pixel whose line store read is in flight
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_last_reg;
    logic               s1_result_reg;

    // Output register
    logic               result_valid_reg;
    logic [PIX_W-1:0]   blurred_value_reg;
    logic [ROW_W-1:0]   window_row_reg;
    logic [OUT_COL_W-1:0] window_col_reg;
    logic               frame_done_reg;

    logic               accept;
    logic               s1_go;
    logic               out_take;
    row_pair_t          store_rd;
    row_pair_t          store_wr;
    column_t            cur_column;
    logic [PIX_W-1:0]   mean;
    logic [31:0]        win_col_wide;
    logic [ROW_W-1:0]   win_row;

    //------------------------------------------------------------------
    // Configuration
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    // Only a write to a real register restarts the frame; spare indexes
    // are ignored.
    assign cfg_restart = cfg_write &&
                         (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W_W'(RESET_WIDTH);
            image_height_reg <= CFG_H_W'(RESET_HEIGHT);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[CFG_W_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[CFG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturation of the frame size: width to 3..MAX_WIDTH, height to 3..4096.
    always_comb
    begin
        if (32'(image_width_reg) < 32'(WIN_SIDE))
            last_col = COL_W'(WIN_SIDE - 1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(32'(image_width_reg) - 32'd1);

        if (32'(image_height_reg) < 32'(WIN_SIDE))
            last_row = ROW_W'(WIN_SIDE - 1);
        else if (32'(image_height_reg) > 32'(HEIGHT_LIMIT))
            last_row = ROW_W'(HEIGHT_LIMIT - 1);
        else
            last_row = ROW_W'(32'(image_height_reg) - 32'd1);
    end

    //------------------------------------------------------------------
    // Handshakes
    //------------------------------------------------------------------
    // Stage 1 drains unless it carries a result and the output register is
    // full and stalled. Items without a result still pass to update state.
    assign out_take    = result_valid_reg && !result_stall;
    assign s1_go       = s1_valid_reg &&
                         (!s1_result_reg || !result_valid_reg || !result_stall);
    assign pixel_stall = s1_valid_reg && !s1_go;
    assign accept      = pixel_valid && !pixel_stall;

    //------------------------------------------------------------------
    // Frame position
    //------------------------------------------------------------------
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    //------------------------------------------------------------------
    // Stage 1
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg  <= gray_pixel;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_last_reg   <= (col_reg == last_col) && (row_reg == last_row);
            s1_result_reg <= (32'(col_reg) >= 32'd2) && (32'(row_reg) >= 32'd2);
        end
    end

    // Line store: read at accept, write back the shifted pair as the pixel
    // leaves stage 1. Back-to-back pixels never share a column, so the read
    // and write never collide.
    assign store_wr.older = store_rd.newer;
    assign store_wr.newer = s1_pixel_reg;

    bb3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (store_rd),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (store_wr)
    );

    assign cur_column.top = store_rd.older;
    assign cur_column.mid = store_rd.newer;
    assign cur_column.bot = s1_pixel_reg;

    bb3_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (s1_go),
        .column (cur_column),
        .mean   (mean)
    );

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    assign win_col_wide = 32'(s1_col_reg) - 32'd2;
    assign win_row      = s1_row_reg - ROW_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_result_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_result_reg)
        begin
            blurred_value_reg <= mean;
            window_row_reg    <= win_row;
            window_col_reg    <= win_col_wide[OUT_COL_W-1:0];
            frame_done_reg    <= s1_last_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign blurred_value = blurred_value_reg;
    assign window_row    = window_row_reg;
    assign window_col    = window_col_reg;
    assign frame_done    = frame_done_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `BB3_ASSERT_NOW(a_empty_no_stall, clk, rst_n, !s1_valid_reg, !pixel_stall, "stall with empty stage 1")
    `BB3_ASSERT_NOW(a_blocked_stalls, clk, rst_n, s1_valid_reg && s1_result_reg && result_valid_reg && result_stall, pixel_stall, "result overwrite possible")
    `BB3_ASSERT_NOW(a_last_has_result, clk, rst_n, s1_valid_reg && s1_last_reg, s1_result_reg, "frame end without a result")
    `BB3_ASSERT_NEXT(a_frame_wrap, clk, rst_n, accept && !cfg_valid && col_reg == last_col && row_reg == last_row, col_reg == '0 && row_reg == '0, "position did not wrap at frame end")

endmodule

@@ tb/box_blur_3x3_tb.sv @@
// Self-checking testbench for the streaming 3x3 box blur.
`timescale 1ns / 100ps

module box_blur_3x3_tb;
    import bb3_pkg::*;

    localparam int MAX_WIDTH      = 1024;
    localparam int CYCLE_LIMIT    = 200000;   // far above the slowest legal run
    localparam int DRAIN_LIMIT    = 50000;    // cycles to wait for results to arrive
    localparam int SETTLE_CYCLES  = 8;        // settling margin after the last owed window
    localparam int RANDOM_ITEMS   = 340;
    localparam int EXTREME_PIXELS = 40;       // short stream on each saturated geometry

    localparam logic [PIX_W-1:0]      PIX_MAX      = '1;
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;
    // Indexes with no register behind them; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_HI = 2'd3;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_CHECKER} fill_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // Scoreboard: mirrors line stores, window and raster position, and
    // queues the blurred windows that the block owes us.
    class blur_scoreboard #(int LINE_DEPTH = 1024);
        localparam int REACH       = WIN_SIDE - 1;
        localparam int WINDOW_AREA = WIN_SIDE * WIN_SIDE;

        typedef struct packed {
            logic [PIX_W-1:0]     value;
            logic [ROW_W-1:0]     row;
            logic [OUT_COL_W-1:0] col;
            logic                 done;
        } blur_result_t;

        logic [PIX_W-1:0] older_line [LINE_DEPTH];
        logic [PIX_W-1:0] newer_line [LINE_DEPTH];
        logic [PIX_W-1:0] strip [6];      // two previous strip columns
        int unsigned      col_pos, row_pos, width_reg, height_reg;
        blur_result_t     pending [$];
        int unsigned      mismatches, checked, frames;

        function new();
            foreach (older_line[i])
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            foreach (strip[i]) strip[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            mismatches = 0;
            checked    = 0;
            frames     = 0;
        endfunction

        // Register values in use are saturated to the legal window sizes.
        function int unsigned eff_width();
            if (width_reg < WIN_SIDE) return WIN_SIDE;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < WIN_SIDE) return WIN_SIDE;
            if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
            return height_reg;
        endfunction

        function int unsigned frame_size();
            return eff_width() * eff_height();
        endfunction

        // Any real register write restarts the raster; spare indexes are ignored.
        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH) width_reg = data[CFG_W_W-1:0];
            else if (idx == CFG_IMAGE_HEIGHT) height_reg = data[CFG_H_W-1:0];
            else return;
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int unsigned      w, h, c, r, total;
            logic [PIX_W-1:0] top, mid;
            blur_result_t     blur;
            w = eff_width();
            h = eff_height();
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h) ? h - 1 : row_pos;
            top = older_line[c];
            mid = newer_line[c];
            older_line[c] = mid;
            newer_line[c] = pix;
            // Only pixels at row >= 2 and col >= 2 close a window, so no
            // window ever straddles a row end.
            if (r >= REACH && c >= REACH)
            begin
                total = int'(top) + int'(mid) + int'(pix);
                foreach (strip[k]) total += strip[k];
                blur.value = PIX_W'(total / WINDOW_AREA);
                blur.row   = ROW_W'(r - REACH);
                blur.col   = OUT_COL_W'(c - REACH);
                blur.done  = (c == w - 1) && (r == h - 1);
                pending.push_back(blur);
            end
            strip[0] = strip[3];
            strip[1] = strip[4];
            strip[2] = strip[5];
            strip[3] = top;
            strip[4] = mid;
            strip[5] = pix;
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [PIX_W-1:0] value, logic [ROW_W-1:0] row,
                          logic [OUT_COL_W-1:0] col, logic done);
            blur_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected window (%0d,%0d) value %0d", row, col, value));
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                if (done === 1'b1) frames++;
                if (value !== want.value)
                    report($sformatf("window (%0d,%0d) value %0d, want %0d",
                                     want.row, want.col, value, want.value));
                if (row !== want.row)
                    report($sformatf("window row %0d, want %0d", row, want.row));
                if (col !== want.col)
                    report($sformatf("window col %0d, want %0d", col, want.col));
                if (done !== want.done)
                    report($sformatf("window (%0d,%0d) frame_done %0b, want %0b",
                                     want.row, want.col, done, want.done));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      gray_pixel;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [PIX_W-1:0]      blurred_value;
    logic [ROW_W-1:0]      window_row;
    logic [OUT_COL_W-1:0]  window_col;
    logic                  frame_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blur_scoreboard #(MAX_WIDTH) sb;

    int unsigned cycle_count   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned random_pixels = 0;
    int unsigned cfg_writes    = 0;
    int          gap_max       = 0;   // 0: sender never idles
    int          burst_left    = 0;
    stall_mode_t stall_mode    = STALL_NONE;
    int          stall_left    = 0;

    box_blur_3x3 #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .gray_pixel    (gray_pixel),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .blurred_value (blurred_value),
        .window_row    (window_row),
        .window_col    (window_col),
        .frame_done    (frame_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver backpressure: the pattern switches at random between none,
    // light, heavy and periodic stalls.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(30, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
            default:     result_stall <= (stall_left % 5 < 2);
        endcase
    end

    // Result monitor and run watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run hit the cycle limit with %0d windows outstanding",
                     sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
        else if (rst_n && result_valid && !result_stall)
            sb.check_result(blurred_value, window_row, window_col, frame_done);
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Waits until every owed window has come out, then lets the pipe settle.
    task drain_results();
        int waited;
        waited = 0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.report($sformatf("%0d windows never came out", sb.pending.size()));
            sb.pending.delete();
        end
    endtask

    // Called at a falling edge while the block is idle.
    task program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_register(idx, data);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Burst/gap pacing after each pixel transaction. Valid is only dropped
    // when a real gap follows or the stream ends.
    task pace(bit last);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            if (gap_max > 0) gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(0, 16);
        end
        else
            burst_left--;
        if (gap > 0 || last)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Streams count pixels; at index pause_at the sender holds off until
    // every owed window has arrived.
    task send_stream(int count, fill_t fill, int pause_at);
        logic [PIX_W-1:0] p;
        for (int i = 0; i < count; i++)
        begin
            case (fill)
                FILL_ZERO:    p = '0;
                FILL_FULL:    p = PIX_MAX;
                FILL_CHECKER: p = i[0] ? PIX_MAX : '0;
                default:      p = pick_pixel();
            endcase
            gray_pixel  <= p;
            pixel_valid <= 1'b1;
            do @(posedge clk); while (pixel_stall);
            sb.note_pixel(p);
            pixels_sent++;
            @(negedge clk);
            if (i == pause_at)
            begin
                pixel_valid <= 1'b0;
                drain_results();
            end
            else
                pace(i == count - 1);
        end
    endtask

    // One random phase: new frame geometry (sometimes out of range or with
    // stray upper bits), then whole frames or a partial one, occasionally
    // broken by a spare-index write that must not disturb the raster.
    task run_random_phase(bit first);
        int unsigned w_data, h_data, count, split;
        int          pause_at;
        bit          spare;
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        case ($urandom_range(0, 9))
            0:       w_data = $urandom_range(0, 2);
            1:       w_data = ($urandom_range(1, 3) << CFG_W_W) | $urandom_range(3, 12);
            default: w_data = $urandom_range(3, 12);
        endcase
        h_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        // The first phase must replace the tall geometry left by the extremes.
        case (first ? 2 : $urandom_range(0, 3))
            0:       program_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_data));
            1:       program_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_data));
            default:
            begin
                program_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_data));
                program_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_data));
            end
        endcase
        if ($urandom_range(0, 1))
            count = sb.frame_size() * $urandom_range(1, 2);
        else
            count = $urandom_range(2, 2 * sb.frame_size());
        pause_at = (first || $urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
        spare    = !first && ($urandom_range(0, 4) == 0);
        split    = spare ? $urandom_range(1, count - 1) : count;
        send_stream(split, FILL_RANDOM, pause_at);
        if (spare)
        begin
            drain_results();
            program_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                             CFG_DATA_W'($urandom));
            send_stream(count - split, FILL_RANDOM, -1);
        end
        random_pixels += count;
        drain_results();
    endtask

    initial
    begin
        bit first;
        sb          = new();
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        gray_pixel  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_IMAGE_WIDTH;
        cfg_data    = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 3x3 frames via undersized register values (0 and 2 both
        // saturate to 3); all-white, checkerboard and all-black windows.
        program_register(CFG_IMAGE_WIDTH, '0);
        program_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        send_stream(9, FILL_FULL, -1);
        send_stream(9, FILL_CHECKER, -1);
        send_stream(9, FILL_ZERO, -1);
        drain_results();

        // Extremes: all-ones width saturates to the full line store, then an
        // all-ones height saturates to 4096 rows on a narrow frame; a short
        // stream runs on each.
        gap_max = 2;
        program_register(CFG_IMAGE_WIDTH, CFG_ALL_ONES);
        program_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(WIN_SIDE));
        send_stream(EXTREME_PIXELS, FILL_RANDOM, -1);
        drain_results();
        program_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(WIN_SIDE));
        program_register(CFG_IMAGE_HEIGHT, CFG_ALL_ONES);
        send_stream(EXTREME_PIXELS, FILL_RANDOM, -1);
        drain_results();

        // Random geometry and content.
        first = 1'b1;
        while (random_pixels < RANDOM_ITEMS)
        begin
            run_random_phase(first);
            first = 1'b0;
        end
        drain_results();

        $display("Sent %0d pixel transactions and %0d register writes; checked %0d windows, %0d frames closed.",
                 pixels_sent, cfg_writes, sb.checked, sb.frames);
        $display("Frames from 3x3 up to saturated width and height, with restarts and stalls.");
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
